### sv/mr_pkg.sv
// Shared types, constants and base tables of the Miller-Rabin primality tester.
`timescale 1ns / 1ps
package mr_pkg;

   // Default candidate width and width of a base constant.
   localparam int NUMBER_WIDTH_DEF = 64;
   localparam int BASE_W = 7;
   localparam int BIDX_W = 3;

   // Range limits that pick the base set.
   localparam logic [63:0] LIMIT_SMALL = 64'd1373653;
   localparam logic [63:0] LIMIT_MID   = 64'd9080191;
   localparam logic [63:0] LIMIT_LARGE = 64'd4759123141;

   // Base set chosen by the size of the candidate.
   typedef enum logic [1:0] {
      SET_SMALL,
      SET_MID,
      SET_LARGE,
      SET_HUGE
   } set_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_FACTOR,
      ST_POW_INIT,
      ST_POW_SQ,
      ST_POW_SQ_WAIT,
      ST_POW_MUL_WAIT,
      ST_POW_STEP,
      ST_ROUND_CHECK,
      ST_SQ_WAIT,
      ST_SQ_CHECK,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic shift_d;
      logic pow_init;
      logic exp_next;
      logic mul_start;
      logic mul_by_base;
      logic cnt_load;
      logic cnt_dec;
      logic base_next;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic small_comp;
      logic small_prime;
      logic even;
      logic d_odd;
      logic e_top;
      logic e_last;
      logic mul_done;
      logic x_one;
      logic x_nm1;
      logic cnt_one;
      logic base_last;
   } status_type;

   // Base value at a given place of a set.
   function automatic logic [BASE_W-1:0] base_of(input set_type set, input logic [BIDX_W-1:0] idx);
      logic [BASE_W-1:0] b;
      b = 7'd2;
      unique case (set)
         SET_SMALL: b = (idx == 3'd0) ? 7'd2 : 7'd3;
         SET_MID:   b = (idx == 3'd0) ? 7'd31 : 7'd73;
         SET_LARGE: begin
            case (idx)
               3'd0:    b = 7'd2;
               3'd1:    b = 7'd7;
               default: b = 7'd61;
            endcase
         end
         default: begin
            case (idx)
               3'd0:    b = 7'd2;
               3'd1:    b = 7'd3;
               3'd2:    b = 7'd5;
               3'd3:    b = 7'd7;
               default: b = 7'd11;
            endcase
         end
      endcase
      return b;
   endfunction

   // Index of the last base in a set.
   function automatic logic [BIDX_W-1:0] last_idx(input set_type set);
      logic [BIDX_W-1:0] li;
      unique case (set)
         SET_SMALL: li = 3'd1;
         SET_MID:   li = 3'd1;
         SET_LARGE: li = 3'd2;
         default:   li = 3'd4;
      endcase
      return li;
   endfunction

endpackage

### sv/mr_mulmod.sv
// Bit-serial modular multiplier: double-and-add with reduction, a doubling and a conditional add per bit.
`timescale 1ns / 1ps
module mr_mulmod #(
   parameter int W = mr_pkg::NUMBER_WIDTH_DEF,
   parameter int CW = $clog2(W)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [W-1:0]  x_op,
   input  logic [W-1:0]  y_op,
   input  logic [W-1:0]  m_op,
   input  logic [CW-1:0] top_bit,
   output logic          done,
   output logic [W-1:0]  product
);
   import mr_pkg::*;

   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  y_ff, y_in;
   logic [W-1:0]  m_ff, m_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          phase_ff, phase_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   // (a + b) mod m for a and b below m.
   function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                            input logic [W-1:0] m);
      logic [W-1:0] room;
      room = m - b;
      return (a >= room) ? (a - room) : (a + b);
   endfunction

   // One step each cycle: doubling in the first phase, conditional add in the second.
   always_comb begin
      acc_in   = acc_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      m_in     = m_ff;
      idx_in   = idx_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         acc_in   = '0;
         x_in     = x_op;
         y_in     = y_op;
         m_in     = m_op;
         idx_in   = top_bit;
         phase_in = 1'b0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            acc_in   = add_mod(acc_ff, acc_ff, m_ff);
            phase_in = 1'b1;
         end else begin
            if (y_ff[idx_ff]) begin
               acc_in = add_mod(acc_ff, x_ff, m_ff);
            end
            phase_in = 1'b0;
            if (idx_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
      end
   end

   // Control flops take reset; operands do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff   <= acc_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      m_ff     <= m_in;
      idx_ff   <= idx_in;
      phase_ff <= phase_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

   // A new product is never started over one in progress.
   a_no_restart: assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("multiplier started while busy");
   // Completion is a one-cycle pulse that ends a busy period.
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (!busy_ff && $past(busy_ff)))
      else $error("done without a preceding busy period");
   // The running sum stays reduced.
   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start) |-> (acc_ff < m_ff))
      else $error("accumulator left its residue range");

endmodule

### sv/mr_datapath.sv
// Datapath: candidate, odd part, exponent scan, round value and the modular multiplier.
`timescale 1ns / 1ps
module mr_datapath #(
   parameter int W = mr_pkg::NUMBER_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  mr_pkg::cmd_type    cmd,
   input  logic [63:0]        candidate,
   output mr_pkg::status_type status
);
   import mr_pkg::*;

   localparam int CW = $clog2(W);

   logic [W-1:0]      n_ff, n_in;
   logic [W-1:0]      d_ff, d_in;
   logic [CW-1:0]     r_ff, r_in;
   logic [W-1:0]      e_ff, e_in;
   logic [CW-1:0]     ecnt_ff, ecnt_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [W-1:0]      x_ff, x_in;
   set_type           set_ff, set_in;
   logic [BIDX_W-1:0] bidx_ff, bidx_in;
   logic [W-1:0]      n_new;
   logic [63:0]       n_new_wide;
   logic [W-1:0]      nm1;
   logic [W-1:0]      mul_x;
   logic [W-1:0]      mul_y;
   logic [CW-1:0]     mul_top;
   logic              mul_done;
   logic [W-1:0]      mul_prod;

   assign n_new      = candidate[W-1:0];
   assign n_new_wide = 64'(n_new);
   assign nm1        = n_ff - 1'b1;

   // A product that starts as the previous one finishes takes the fresh result.
   assign mul_x = mul_done ? mul_prod : x_ff;

   // Operand selection: a full squaring or a short product by the base.
   assign mul_y   = cmd.mul_by_base ? W'(base_of(set_ff, bidx_ff)) : x_ff;
   assign mul_top = cmd.mul_by_base ? CW'(BASE_W - 1) : CW'(W - 1);

   mr_mulmod #(.W(W), .CW(CW)) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .x_op    (mul_x),
      .y_op    (mul_y),
      .m_op    (n_ff),
      .top_bit (mul_top),
      .done    (mul_done),
      .product (mul_prod)
   );

   // Register updates under controller command.
   always_comb begin
      n_in    = n_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      e_in    = e_ff;
      ecnt_in = ecnt_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      set_in  = set_ff;
      bidx_in = bidx_ff;
      if (cmd.load) begin
         n_in    = n_new;
         d_in    = n_new - 1'b1;
         r_in    = '0;
         bidx_in = '0;
         if (n_new_wide < LIMIT_SMALL) begin
            set_in = SET_SMALL;
         end else if (n_new_wide < LIMIT_MID) begin
            set_in = SET_MID;
         end else if (n_new_wide < LIMIT_LARGE) begin
            set_in = SET_LARGE;
         end else begin
            set_in = SET_HUGE;
         end
      end
      if (cmd.shift_d) begin
         d_in = d_ff >> 1;
         r_in = r_ff + 1'b1;
      end
      if (cmd.pow_init) begin
         x_in    = W'(1);
         e_in    = d_ff;
         ecnt_in = '0;
      end
      if (cmd.exp_next) begin
         e_in    = e_ff << 1;
         ecnt_in = ecnt_ff + 1'b1;
      end
      if (cmd.cnt_load) begin
         cnt_in = r_ff;
      end
      if (cmd.cnt_dec) begin
         cnt_in = cnt_ff - 1'b1;
      end
      if (cmd.base_next) begin
         bidx_in = bidx_ff + 1'b1;
      end
      if (mul_done) begin
         x_in = mul_prod;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      d_ff    <= d_in;
      r_ff    <= r_in;
      e_ff    <= e_in;
      ecnt_ff <= ecnt_in;
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      set_ff  <= set_in;
      bidx_ff <= bidx_in;
   end

   // Status flags for the controller.
   always_comb begin
      status.small_comp  = (n_ff <= W'(1)) || (n_ff == W'(4));
      status.small_prime = (n_ff == W'(2)) || (n_ff == W'(3));
      status.even        = !n_ff[0];
      status.d_odd       = d_ff[0];
      status.e_top       = e_ff[W-1];
      status.e_last      = (ecnt_ff == CW'(W - 1));
      status.mul_done    = mul_done;
      status.x_one       = (x_ff == W'(1));
      status.x_nm1       = (x_ff == nm1);
      status.cnt_one     = (cnt_ff == CW'(1));
      status.base_last   = (bidx_ff == last_idx(set_ff));
   end

endmodule

### sv/mr_ctrl.sv
// Controller: sequences classification, factoring, exponentiation and the squaring rounds.
`timescale 1ns / 1ps
module mr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_is_prime,
   input  mr_pkg::status_type status,
   output mr_pkg::cmd_type    cmd
);
   import mr_pkg::*;

   state_type state_ff, state_in;
   logic      verdict_ff, verdict_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_is_prime_ff, rsp_is_prime_in;

   // Next state.
   always_comb begin
      state_in   = state_ff;
      verdict_in = verdict_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            if (status.small_comp) begin
               verdict_in = 1'b0;
               state_in   = ST_DONE;
            end else if (status.small_prime) begin
               verdict_in = 1'b1;
               state_in   = ST_DONE;
            end else if (status.even) begin
               verdict_in = 1'b0;
               state_in   = ST_DONE;
            end else begin
               state_in = ST_FACTOR;
            end
         end
         ST_FACTOR: begin
            if (status.d_odd) state_in = ST_POW_INIT;
         end
         ST_POW_INIT: state_in = ST_POW_SQ;
         ST_POW_SQ:   state_in = ST_POW_SQ_WAIT;
         ST_POW_SQ_WAIT: begin
            if (status.mul_done) begin
               state_in = status.e_top ? ST_POW_MUL_WAIT : ST_POW_STEP;
            end
         end
         ST_POW_MUL_WAIT: begin
            if (status.mul_done) state_in = ST_POW_STEP;
         end
         ST_POW_STEP: begin
            state_in = status.e_last ? ST_ROUND_CHECK : ST_POW_SQ;
         end
         ST_ROUND_CHECK, ST_SQ_CHECK: begin
            if (status.x_nm1 || (state_ff == ST_ROUND_CHECK && status.x_one)) begin
               if (status.base_last) begin
                  verdict_in = 1'b1;
                  state_in   = ST_DONE;
               end else begin
                  state_in = ST_POW_INIT;
               end
            end else if (status.x_one || status.cnt_one) begin
               verdict_in = 1'b0;
               state_in   = ST_DONE;
            end else begin
               state_in = ST_SQ_WAIT;
            end
         end
         ST_SQ_WAIT: begin
            if (status.mul_done) state_in = ST_SQ_CHECK;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands and result register.
   always_comb begin
      cmd             = '0;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_is_prime_in = rsp_is_prime_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
         end
         ST_CLASSIFY: ;
         ST_FACTOR: begin
            cmd.shift_d = !status.d_odd;
         end
         ST_POW_INIT: begin
            cmd.pow_init = 1'b1;
         end
         ST_POW_SQ: begin
            cmd.mul_start = 1'b1;
         end
         ST_POW_SQ_WAIT: begin
            cmd.mul_start   = status.mul_done && status.e_top;
            cmd.mul_by_base = 1'b1;
         end
         ST_POW_MUL_WAIT: ;
         ST_POW_STEP: begin
            cmd.exp_next = !status.e_last;
            cmd.cnt_load = status.e_last;
         end
         ST_ROUND_CHECK, ST_SQ_CHECK: begin
            if (status.x_nm1 || (state_ff == ST_ROUND_CHECK && status.x_one)) begin
               cmd.base_next = !status.base_last;
            end else if (!(status.x_one || status.cnt_one)) begin
               cmd.mul_start = 1'b1;
               cmd.cnt_dec   = 1'b1;
            end
         end
         ST_SQ_WAIT: ;
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_is_prime_in = verdict_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      verdict_ff      <= verdict_in;
      rsp_is_prime_ff <= rsp_is_prime_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

   // An item is only taken in the idle state.
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (state_ff == ST_IDLE))
      else $error("load outside idle");
   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_is_prime_ff)))
      else $error("stalled result changed");
   // Leaving the done state always presents a result.
   a_done_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("result lost");

endmodule

### sv/miller_rabin_primality_test_top.sv
// Top level of the deterministic Miller-Rabin primality tester.
//
// Input channel req_: one candidate per transfer on req_candidate (low NUMBER_WIDTH
// bits used). Result channel rsp_: one transfer per candidate, rsp_is_prime is 1 for a
// probable prime under the size-selected base set and 0 for a composite.
// A transfer happens on a clock edge with valid high and stall low.
// One candidate is worked on at a time; req_stall is high from acceptance until the
// result has been placed in the output register.
// Trivial candidates (small, even) go from classification straight to the result.
// Odd candidates first strip the r factors of two from n-1, then per base run
// NUMBER_WIDTH exponent steps, each a full squaring followed by the step itself,
// plus one short multiply by the base for each set bit of the odd part,
// then up to r-1 further squarings, all on the bit-serial modular multiplier.
// The result register holds its value while rsp_stall is high; the block returns to
// idle and takes the next candidate once the result has been loaded.
// Synchronous reset returns the controller to idle and drops rsp_valid.
`timescale 1ns / 1ps
module miller_rabin_primality_test_top #(
   parameter int NUMBER_WIDTH = mr_pkg::NUMBER_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_candidate,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_prime
);
   import mr_pkg::*;

   cmd_type    cmd;
   status_type status;

   mr_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_is_prime (rsp_is_prime),
      .status       (status),
      .cmd          (cmd)
   );

   mr_datapath #(.W(NUMBER_WIDTH)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .candidate (req_candidate),
      .status    (status)
   );

endmodule
